FILE: rtl/cis_pkg.sv
// Shared constants, types and character-class functions for the identifier scanner.
package cis_pkg;

	localparam int unsigned ModeW = 4;

	// Scan mode codes
	localparam logic [ModeW-1:0] MODE_NORMAL   = 4'd0;
	localparam logic [ModeW-1:0] MODE_SLASH    = 4'd1;
	localparam logic [ModeW-1:0] MODE_BLOCK    = 4'd2;
	localparam logic [ModeW-1:0] MODE_BLOCK_ST = 4'd3;
	localparam logic [ModeW-1:0] MODE_LINE     = 4'd4;
	localparam logic [ModeW-1:0] MODE_STR      = 4'd5;
	localparam logic [ModeW-1:0] MODE_STR_ESC  = 4'd6;
	localparam logic [ModeW-1:0] MODE_CHR      = 4'd7;
	localparam logic [ModeW-1:0] MODE_CHR_ESC  = 4'd8;
	localparam logic [ModeW-1:0] MODE_IDENT    = 4'd9;

	// Characters of interest
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_UNDER   = 8'h5F;

	typedef struct packed {
		logic valid;
		logic first;
		logic closed;
	} cis_flags_t;

	function automatic logic is_head(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			(c == CH_UNDER);
	endfunction

	function automatic logic is_tail(input logic [7:0] c);
		return is_head(c) || ((c >= 8'h30) && (c <= 8'h39));
	endfunction

endpackage

FILE: rtl/cis_scan.sv
// Next-mode and identifier-flag logic for one text byte.
module cis_scan import cis_pkg::*; (
	input  logic [ModeW-1:0] mode,
	input  logic [7:0]       text_byte,
	input  logic             end_of_text,
	output logic [ModeW-1:0] mode_next,
	output cis_flags_t       flags
);

	logic [ModeW-1:0] norm_mode;
	logic             norm_start;
	logic [ModeW-1:0] raw_next;
	logic             starts;
	logic             tail_ok;
	logic             closed_raw;

	// byte taken as plain text
	always_comb begin
		norm_start = 1'b0;
		priority if (is_head(text_byte)) begin
			norm_mode  = MODE_IDENT;
			norm_start = 1'b1;
		end else if (text_byte == CH_SLASH) begin
			norm_mode = MODE_SLASH;
		end else if (text_byte == CH_DQUOTE) begin
			norm_mode = MODE_STR;
		end else if (text_byte == CH_SQUOTE) begin
			norm_mode = MODE_CHR;
		end else begin
			norm_mode = MODE_NORMAL;
		end
	end

	assign tail_ok = is_tail(text_byte);

	always_comb begin
		starts     = 1'b0;
		closed_raw = 1'b0;
		unique case (mode)
			MODE_SLASH: begin
				priority if (text_byte == CH_STAR) raw_next = MODE_BLOCK;
				else if (text_byte == CH_SLASH) raw_next = MODE_LINE;
				else begin
					raw_next = norm_mode;
					starts   = norm_start;
				end
			end
			MODE_BLOCK: raw_next = (text_byte == CH_STAR) ? MODE_BLOCK_ST : MODE_BLOCK;
			MODE_BLOCK_ST: begin
				priority if (text_byte == CH_SLASH) raw_next = MODE_NORMAL;
				else if (text_byte == CH_STAR) raw_next = MODE_BLOCK_ST;
				else raw_next = MODE_BLOCK;
			end
			MODE_LINE: raw_next = (text_byte == CH_NL) ? MODE_NORMAL : MODE_LINE;
			MODE_STR: begin
				priority if (text_byte == CH_BSLASH) raw_next = MODE_STR_ESC;
				else if (text_byte == CH_DQUOTE) raw_next = MODE_NORMAL;
				else raw_next = MODE_STR;
			end
			MODE_STR_ESC: raw_next = MODE_STR;
			MODE_CHR: begin
				priority if (text_byte == CH_BSLASH) raw_next = MODE_CHR_ESC;
				else if (text_byte == CH_SQUOTE) raw_next = MODE_NORMAL;
				else raw_next = MODE_CHR;
			end
			MODE_CHR_ESC: raw_next = MODE_CHR;
			MODE_IDENT: begin
				if (tail_ok) begin
					raw_next = MODE_IDENT;
				end else begin
					closed_raw = 1'b1;
					raw_next   = norm_mode;
					starts     = norm_start;
				end
			end
			default: begin
				// normal text, and unused codes
				raw_next = norm_mode;
				starts   = norm_start;
			end
		endcase
	end

	always_comb begin
		flags.valid  = starts || ((mode == MODE_IDENT) && tail_ok);
		flags.first  = starts;
		flags.closed = closed_raw || (end_of_text && flags.valid);
		mode_next    = end_of_text ? MODE_NORMAL : raw_next;
	end

endmodule

FILE: rtl/c_source_identifier_scanner.sv
// Top level of the C source identifier scanner: input register, mode register, result register.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------------
//  in      | in_valid, in_stall  | text_byte[7:0], end_of_text
//  out     | out_valid, out_stall| ident_byte[7:0], ident_valid, ident_first, ident_closed
//
// One word in, one word out. An accepted word passes from input register to result register;
// throughput is one word per cycle while not stalled, set by the single mode register update.
// arst_n clears the valid bits of both stages and returns the scan mode to normal text.
// A stalled result holds; the input register keeps accepting while the result
// register is empty or being drained, so in_stall rises only when both are full.
module c_source_identifier_scanner import cis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] ident_byte,
	output logic       ident_valid,
	output logic       ident_first,
	output logic       ident_closed
);

	// stage 1: registered input word
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eot_s1;

	// scan state
	logic [ModeW-1:0] mode_q;
	logic [ModeW-1:0] mode_next;
	cis_flags_t       flags;

	// stage 2: registered result word
	logic             valid_s2;
	logic [7:0]       byte_s2;
	cis_flags_t       flags_s2;

	logic             load_s2;
	logic             load_s1;
	logic             adv_s1;

	// result register takes a word when empty or when its word leaves this cycle
	assign load_s2  = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && load_s2;
	// input register frees up when its word moves on
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	cis_scan u_scan (
		.mode        (mode_q),
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.mode_next   (mode_next),
		.flags       (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mode_q   <= MODE_NORMAL;
		end else begin
			if (load_s1 || adv_s1) valid_s1 <= load_s1;
			if (load_s2) valid_s2 <= valid_s1;
			// mode advances exactly once per word, when it moves to the result stage
			if (adv_s1) mode_q <= mode_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
		if (adv_s1) begin
			byte_s2  <= flags.valid ? byte_s1 : 8'h00;
			flags_s2 <= flags;
		end
	end

	assign out_valid    = valid_s2;
	assign ident_byte   = byte_s2;
	assign ident_valid  = flags_s2.valid;
	assign ident_first  = flags_s2.first;
	assign ident_closed = flags_s2.closed;

`ifndef SYNTHESIS
	// a word starting an identifier is itself part of it
	a_first_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ident_first |-> ident_valid)
		else $error("ident_first without ident_valid");

	// non-identifier words carry a zero byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ident_valid |-> ident_byte == 8'h00)
		else $error("ident_byte nonzero outside identifier");

	// the last word of a text returns the scanner to normal text
	a_eot_resets_mode: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && eot_s1 |=> mode_q == MODE_NORMAL)
		else $error("mode not normal after end of text");

	// mode only changes when a word moves to the result stage
	a_mode_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(mode_q))
		else $error("mode changed without a word");
`endif

endmodule

FILE: bench/ident_scan_checker.sv
// Checker for the identifier scanner: predicts every result word and compares it on arrival.
`timescale 1ns / 100ps

module ident_scan_checker import cis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] ident_byte,
	input  logic       ident_valid,
	input  logic       ident_first,
	input  logic       ident_closed,
	output int         mismatch_total,
	output int         words_pending
);

	typedef struct packed {
		logic [7:0] text;
		logic       valid;
		logic       first;
		logic       closed;
	} ident_word_t;

	typedef struct packed {
		ident_word_t      word;
		logic [ModeW-1:0] next_mode;
	} scan_step_t;

	logic [ModeW-1:0] scan_state;
	ident_word_t      expected_words[$];
	ident_word_t      got_word;
	ident_word_t      want_word;
	scan_step_t       step;
	int               errors;

	function automatic logic name_start(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER});
	endfunction

	function automatic logic name_part(input logic [7:0] c);
		return name_start(c) || (c inside {[8'h30:8'h39]});
	endfunction

	// Mode reached from plain text.
	function automatic logic [ModeW-1:0] plain_mode(input logic [7:0] c);
		if (name_start(c))
			return MODE_IDENT;
		if (c == CH_SLASH)
			return MODE_SLASH;
		if (c == CH_DQUOTE)
			return MODE_STR;
		if (c == CH_SQUOTE)
			return MODE_CHR;
		return MODE_NORMAL;
	endfunction

	function automatic scan_step_t scan_byte(input logic [7:0] c, input logic last,
			input logic [ModeW-1:0] mode);
		logic [ModeW-1:0] nxt;
		logic             plain;
		logic             hit;
		logic             first;
		logic             closed;
		scan_step_t       r;
		nxt = MODE_NORMAL;
		plain = 1'b0;
		hit = 1'b0;
		first = 1'b0;
		closed = 1'b0;
		case (mode)
			MODE_SLASH: begin
				if (c == CH_STAR)
					nxt = MODE_BLOCK;
				else if (c == CH_SLASH)
					nxt = MODE_LINE;
				else
					plain = 1'b1;
			end
			MODE_BLOCK: nxt = (c == CH_STAR) ? MODE_BLOCK_ST : MODE_BLOCK;
			MODE_BLOCK_ST: begin
				if (c == CH_SLASH)
					nxt = MODE_NORMAL;
				else if (c == CH_STAR)
					nxt = MODE_BLOCK_ST;
				else
					nxt = MODE_BLOCK;
			end
			MODE_LINE: nxt = (c == CH_NL) ? MODE_NORMAL : MODE_LINE;
			MODE_STR: begin
				if (c == CH_BSLASH)
					nxt = MODE_STR_ESC;
				else if (c == CH_DQUOTE)
					nxt = MODE_NORMAL;
				else
					nxt = MODE_STR;
			end
			MODE_STR_ESC: nxt = MODE_STR;
			MODE_CHR: begin
				if (c == CH_BSLASH)
					nxt = MODE_CHR_ESC;
				else if (c == CH_SQUOTE)
					nxt = MODE_NORMAL;
				else
					nxt = MODE_CHR;
			end
			MODE_CHR_ESC: nxt = MODE_CHR;
			MODE_IDENT: begin
				if (name_part(c)) begin
					hit = 1'b1;
					nxt = MODE_IDENT;
				end else begin
					closed = 1'b1;
					plain = 1'b1;
				end
			end
			default: plain = 1'b1;
		endcase
		if (plain) begin
			nxt = plain_mode(c);
			first = name_start(c);
			hit = hit | first;
		end
		// end of text closes an open name and starts the next text fresh
		if (last) begin
			closed = closed | hit;
			nxt = MODE_NORMAL;
		end
		r.word.text = hit ? c : 8'h00;
		r.word.valid = hit;
		r.word.first = first;
		r.word.closed = closed;
		r.next_mode = nxt;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_state = MODE_NORMAL;
			expected_words.delete();
			errors = 0;
			mismatch_total <= 0;
			words_pending <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				step = scan_byte(text_byte, end_of_text, scan_state);
				scan_state = step.next_mode;
				expected_words.push_back(step.word);
			end
			if (out_valid && !out_stall) begin
				got_word.text = ident_byte;
				got_word.valid = ident_valid;
				got_word.first = ident_first;
				got_word.closed = ident_closed;
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected word byte=%h valid=%b first=%b closed=%b",
							$realtime, got_word.text, got_word.valid, got_word.first,
							got_word.closed);
				end else begin
					want_word = expected_words.pop_front();
					if (got_word !== want_word) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: word mismatch exp byte=%h valid=%b first=%b",
								" closed=%b, got byte=%h valid=%b first=%b closed=%b"},
								$realtime, want_word.text, want_word.valid,
								want_word.first, want_word.closed, got_word.text,
								got_word.valid, got_word.first, got_word.closed);
					end
				end
			end
			mismatch_total <= errors;
			words_pending <= expected_words.size();
		end
	end

endmodule

FILE: bench/c_source_identifier_scanner_test.sv
// Top of the identifier scanner testbench: clock, reset, source text stimulus and verdict.
`timescale 1ns / 100ps

module c_source_identifier_scanner_test import cis_pkg::*;;

	localparam int unsigned RandomWords = 1650;  // random source bytes to push through
	localparam int unsigned GapMax      = 14;    // longest idle gap per word, either side
	localparam int unsigned IdleLimit   = 1000;  // cycles without any transfer => hang

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] text_byte;
	logic       end_of_text;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] ident_byte;
	logic       ident_valid;
	logic       ident_first;
	logic       ident_closed;

	int          mismatch_total;
	int          words_pending;
	bit          in_quiet;       // sender runs back to back while set
	bit          out_quiet;      // receiver starts no new stall while set
	int unsigned stall_left;
	int unsigned stall_draw;
	int unsigned idle_cycles;
	int unsigned random_words;
	logic [7:0]  text_q[$];      // source text being assembled

	c_source_identifier_scanner uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ident_byte  (ident_byte),
		.ident_valid (ident_valid),
		.ident_first (ident_first),
		.ident_closed(ident_closed)
	);

	// The checker sees both channels exactly as the block does and keeps its own
	// copy of the scan mode; it reports failures and what is still outstanding.
	ident_scan_checker ident_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.text_byte     (text_byte),
		.end_of_text   (end_of_text),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ident_byte    (ident_byte),
		.ident_valid   (ident_valid),
		.ident_first   (ident_first),
		.ident_closed  (ident_closed),
		.mismatch_total(mismatch_total),
		.words_pending (words_pending)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: after each accepted word, draw how long to hold stall before the
	// next one. The stall is independent of out_valid, so it also lands on cycles
	// where the result register is empty, and on cycles where the input is full.
	// A nonzero draw raises stall at the same edge and holds it until stall_left runs out.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1)
				out_stall <= 1'b0;
		end else if (out_valid && !out_stall && !out_quiet) begin
			stall_draw = $urandom_range(0, GapMax);
			stall_left <= stall_draw;
			out_stall <= (stall_draw != 0);
		end
	end

	// Hang detection: any cycle with a transfer on either channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// One word on the input channel. Called on a rising edge; returns on the edge
	// where the word was taken. A zero gap keeps in_valid high into the next word,
	// so valid is never dropped and raised within the same step.
	task automatic send_word(input logic [7:0] b, input logic last);
		int unsigned gap;
		gap = in_quiet ? 0 : $urandom_range(0, GapMax);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= last;
		do @(posedge clk); while (in_stall);
	endtask

	// A whole text from a string; the last character carries end_of_text.
	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], i == s.len() - 1);
	endtask

	task automatic send_queue();
		for (int i = 0; i < text_q.size(); i++)
			send_word(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	function automatic logic [7:0] name_char(input bit head);
		int unsigned k;
		k = $urandom_range(0, head ? 52 : 62);
		if (k < 26)
			return 8'(8'h61 + k);
		if (k < 52)
			return 8'(8'h41 + k - 26);
		if (k == 52)
			return CH_UNDER;
		return 8'(8'h30 + k - 53);
	endfunction

	// Literal and comment body: half any byte at all, half printable.
	function automatic logic [7:0] body_char();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	// Append one C-like token to the text. Closing quotes and comment ends are
	// sometimes left off so texts also end inside open constructs.
	task automatic add_token();
		int unsigned kind;
		logic [7:0]  quote;
		string       ops;
		ops = " \n\t;(){}=+-*,<>.#";
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2: begin
				text_q.push_back(name_char(1));
				repeat ($urandom_range(0, 7)) text_q.push_back(name_char(0));
			end
			3: begin
				// numbers: digits start nothing, the x of 0x starts a name
				text_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 1))
					text_q.push_back(8'h78);
				repeat ($urandom_range(0, 4)) text_q.push_back(name_char(0));
			end
			4: text_q.push_back(ops[$urandom_range(0, ops.len() - 1)]);
			5, 6: begin
				quote = (kind == 5) ? CH_DQUOTE : CH_SQUOTE;
				text_q.push_back(quote);
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(0, 3) == 0) begin
						text_q.push_back(CH_BSLASH);
						text_q.push_back($urandom_range(0, 1) ? quote : body_char());
					end else begin
						text_q.push_back(body_char());
					end
				end
				if ($urandom_range(0, 7) != 0)
					text_q.push_back(quote);
			end
			7: begin
				text_q.push_back(CH_SLASH);
				text_q.push_back(CH_STAR);
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 4))
						0: text_q.push_back(CH_STAR);
						1: text_q.push_back(CH_SLASH);
						2: text_q.push_back(CH_NL);
						default: text_q.push_back(body_char());
					endcase
				end
				if ($urandom_range(0, 7) != 0) begin
					text_q.push_back(CH_STAR);
					text_q.push_back(CH_SLASH);
				end
			end
			8: begin
				text_q.push_back(CH_SLASH);
				text_q.push_back($urandom_range(0, 5) ? CH_SLASH : body_char());
				repeat ($urandom_range(0, 8)) text_q.push_back(body_char());
				if ($urandom_range(0, 7) != 0)
					text_q.push_back(CH_NL);
			end
			default: text_q.push_back(8'($urandom_range(0, 255)));
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		text_byte = 8'h00;
		end_of_text = 1'b0;
		out_stall = 1'b0;
		in_quiet = 1'b0;
		out_quiet = 1'b0;
		stall_left = 0;
		random_words = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed texts.
		// NUL byte, digits before a name, lone slash then a name,
		// a name that runs into the end of the text.
		send_word(8'h00, 1'b0);
		send_text("0x1F/_a9Z");
		// slash-star-slash stays in the comment, star-slash ends it; a name cut by
		// a string; escaped quotes in the string, which is left open at the end
		send_text("/*/**/q\"\\\"'\\'");
		// line comment holding 0xFF, ended by newline, then a one-letter name
		send_text("//\377\nz");

		// Random texts, each a run of tokens; pacing changes per text so some
		// texts go through with no idling at all on one or both sides.
		while (random_words < RandomWords) begin
			in_quiet = ($urandom_range(0, 3) == 0);
			out_quiet <= ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 12)) add_token();
			random_words += text_q.size();
			send_queue();
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (words_pending != 0);
		repeat (4) @(posedge clk);
		if (mismatch_total == 0 && words_pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: c_source_identifier_scanner.f
rtl/cis_pkg.sv
rtl/cis_scan.sv
rtl/c_source_identifier_scanner.sv
bench/ident_scan_checker.sv
bench/c_source_identifier_scanner_test.sv
